>>> rtl/nlscan_pkg.sv
// nlscan_pkg: shared widths, result kind codes and the result record
// for the numeric literal scanner; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package nlscan_pkg;

  // field widths
  localparam int LINE_BITS   = 16;
  localparam int LENGTH_BITS = 8;
  localparam int VALUE_BITS  = 63;

  // result kinds
  localparam logic [1:0] K_INT  = 2'd0;
  localparam logic [1:0] K_REAL = 2'd1;
  localparam logic [1:0] K_DOT  = 2'd2;
  localparam logic [1:0] K_EXP  = 2'd3;

  // one character request held in the input register
  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } item_t;

  // one result
  typedef struct packed {
    logic [1:0]             kind;
    logic [LINE_BITS-1:0]   line;
    logic [VALUE_BITS-1:0]  int_value;
    logic                   overflow;
    logic [LENGTH_BITS-1:0] length;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/numeric_literal_scanner.sv
// numeric_literal_scanner: top level, joins input register, scanner core
// and result register; depends on nlscan_pkg and the nlscan_* modules
//
// Usage
// - input channel: in_valid/in_ready with ch and end_of_text; one request is
//   one text character, or end of text (flushes a pending literal, ch unused)
// - output channel: out_valid/out_ready with kind, line, int_value, overflow
//   and length; a request gives zero or one result
// - throughput: one character per cycle while the result register has room;
//   the whole scan step (state machine, times-ten accumulate with saturation,
//   counters) is combinational from the input register to the result register
// - path: the accepting edge loads the input register, and the held
//   character's result, if any, is loaded into the result register when
//   that register has room, which raises out_valid
// - reset: rst is synchronous; scanner goes to skipping state, line count
//   to one, both registers empty
// - stall: while a result waits for out_ready, the held character waits in
//   the input register and in_ready drops once that register is full;
//   nothing is lost or repeated
`timescale 1ns / 1ps
`default_nettype none

module numeric_literal_scanner (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [7:0]                         ch,
  input  wire logic                               end_of_text,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [1:0]                              kind,
  output logic [nlscan_pkg::LINE_BITS-1:0]        line,
  output logic [nlscan_pkg::VALUE_BITS-1:0]       int_value,
  output logic                                    overflow,
  output logic [nlscan_pkg::LENGTH_BITS-1:0]      length
);
  import nlscan_pkg::*;

  item_t in_item, held_item;
  logic  held_valid, fire, emit;
  res_t  core_res, res_q;

  assign in_item.ch          = ch;
  assign in_item.end_of_text = end_of_text;

  // held request moves on when the result register has room
  assign fire = held_valid && (!out_valid || out_ready);

  nlscan_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .fire       (fire),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  nlscan_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (held_item),
    .emit (emit),
    .res  (core_res)
  );

  nlscan_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire && emit),
    .res_in    (core_res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_q     (res_q)
  );

  // result fields to ports
  assign kind      = res_q.kind;
  assign line      = res_q.line;
  assign int_value = res_q.int_value;
  assign overflow  = res_q.overflow;
  assign length    = res_q.length;

endmodule

`default_nettype wire

>>> rtl/nlscan_in_reg.sv
// nlscan_in_reg: input register for character requests
// depends on nlscan_pkg
`timescale 1ns / 1ps
`default_nettype none

module nlscan_in_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire nlscan_pkg::item_t in_item,
  input  wire logic          fire,
  output logic               held_valid,
  output nlscan_pkg::item_t  held_item
);
  import nlscan_pkg::*;

  // room when empty or the held request moves on this cycle
  assign in_ready = !held_valid || fire;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

`default_nettype wire

>>> rtl/nlscan_core.sv
// nlscan_core: literal recognition state machine, times-ten accumulator,
// line and length counters; depends on nlscan_pkg
`timescale 1ns / 1ps
`default_nettype none

module nlscan_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire nlscan_pkg::item_t item,
  output logic                   emit,
  output nlscan_pkg::res_t       res
);
  import nlscan_pkg::*;

  // scan states
  localparam logic [2:0] ST_SKIP = 3'd0;
  localparam logic [2:0] ST_INT  = 3'd1;
  localparam logic [2:0] ST_DOTP = 3'd2;
  localparam logic [2:0] ST_FRAC = 3'd3;
  localparam logic [2:0] ST_EXPS = 3'd4;
  localparam logic [2:0] ST_SIGN = 3'd5;
  localparam logic [2:0] ST_EXPD = 3'd6;

  // characters of interest
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_EUP   = 8'h45;
  localparam logic [7:0] CH_ELO   = 8'h65;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NL    = 8'h0a;

  // length steps
  localparam logic [LENGTH_BITS:0] LEN_ONE = (LENGTH_BITS+1)'(1);
  localparam logic [LENGTH_BITS:0] LEN_TWO = (LENGTH_BITS+1)'(2);

  localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;
  // largest accumulator that can still take a digit without passing the maximum
  localparam logic [VALUE_BITS-1:0] LIMIT_LO = (VALUE_MAX - 63'd7) / 63'd10;
  localparam logic [VALUE_BITS-1:0] LIMIT_HI = (VALUE_MAX - 63'd9) / 63'd10;

  logic [2:0]             scan_state, scan_state_next;
  logic [LINE_BITS-1:0]   line_count, line_count_next;
  logic [VALUE_BITS-1:0]  value_accum, value_accum_next;
  logic                   value_saturated, value_saturated_next;
  logic [LENGTH_BITS-1:0] literal_length, literal_length_next;

  logic                   is_dig, is_dot, is_e, is_sign;
  logic [3:0]             digit;
  logic [VALUE_BITS-1:0]  limit, times_ten;
  logic [LENGTH_BITS:0]   len_sum;
  logic [LENGTH_BITS:0]   len_inc;
  logic [LENGTH_BITS-1:0] len_grown;
  logic                   take_digit;
  logic [1:0]             emit_kind;

  // character classes; end of text reads as whitespace
  assign is_dig  = !item.end_of_text && item.ch >= CH_ZERO && item.ch <= CH_NINE;
  assign is_dot  = !item.end_of_text && item.ch == CH_DOT;
  assign is_e    = !item.end_of_text && (item.ch == CH_EUP || item.ch == CH_ELO);
  assign is_sign = !item.end_of_text && (item.ch == CH_PLUS || item.ch == CH_MINUS);
  assign digit   = item.ch[3:0];

  // saturating accumulate of one decimal digit
  assign limit     = (digit >= 4'd8) ? LIMIT_HI : LIMIT_LO;
  assign times_ten = {value_accum[VALUE_BITS-4:0], 3'b000}
                   + {value_accum[VALUE_BITS-2:0], 1'b0}
                   + {{(VALUE_BITS-4){1'b0}}, digit};

  // saturating length growth
  assign len_sum   = {1'b0, literal_length} + len_inc;
  assign len_grown = len_sum[LENGTH_BITS] ? '1 : len_sum[LENGTH_BITS-1:0];

  // next state
  always_comb begin
    scan_state_next      = scan_state;
    value_accum_next     = value_accum;
    value_saturated_next = value_saturated;
    literal_length_next  = literal_length;
    len_inc              = '0;
    take_digit           = 1'b0;
    emit                 = 1'b0;
    emit_kind            = K_INT;
    unique case (scan_state)
      ST_SKIP: begin
        if (is_dig) begin
          scan_state_next      = ST_INT;
          value_accum_next     = {{(VALUE_BITS-4){1'b0}}, digit};
          value_saturated_next = 1'b0;
          literal_length_next  = {{(LENGTH_BITS-1){1'b0}}, 1'b1};
        end
      end
      ST_INT: begin
        if (is_dig) begin
          take_digit = 1'b1;
          len_inc    = LEN_ONE;
        end else if (is_dot) begin
          scan_state_next = ST_DOTP;
        end else if (is_e) begin
          len_inc         = LEN_ONE;
          scan_state_next = ST_EXPS;
        end else begin
          emit = 1'b1;
        end
      end
      ST_DOTP: begin
        if (is_dig) begin
          len_inc         = LEN_TWO;
          scan_state_next = ST_FRAC;
        end else begin
          emit = 1'b1;
        end
      end
      ST_FRAC: begin
        if (is_dig) begin
          len_inc = LEN_ONE;
        end else if (is_dot) begin
          len_inc   = LEN_ONE;
          emit      = 1'b1;
          emit_kind = K_DOT;
        end else if (is_e) begin
          len_inc         = LEN_ONE;
          scan_state_next = ST_EXPS;
        end else begin
          emit      = 1'b1;
          emit_kind = K_REAL;
        end
      end
      ST_EXPS: begin
        if (is_e) begin
          len_inc   = LEN_ONE;
          emit      = 1'b1;
          emit_kind = K_EXP;
        end else if (is_sign) begin
          len_inc         = LEN_ONE;
          scan_state_next = ST_SIGN;
        end else if (is_dig) begin
          len_inc         = LEN_ONE;
          scan_state_next = ST_EXPD;
        end else begin
          emit      = 1'b1;
          emit_kind = K_EXP;
        end
      end
      ST_SIGN: begin
        if (is_sign) begin
          len_inc   = LEN_ONE;
          emit      = 1'b1;
          emit_kind = K_EXP;
        end else if (is_dig) begin
          len_inc         = LEN_ONE;
          scan_state_next = ST_EXPD;
        end else begin
          emit      = 1'b1;
          emit_kind = K_EXP;
        end
      end
      ST_EXPD: begin
        if (is_dig) begin
          len_inc = LEN_ONE;
        end else if (is_e) begin
          len_inc   = LEN_ONE;
          emit      = 1'b1;
          emit_kind = K_EXP;
        end else begin
          emit      = 1'b1;
          emit_kind = K_REAL;
        end
      end
      default: begin
        scan_state_next = ST_SKIP;
      end
    endcase

    if (scan_state != ST_SKIP) begin
      literal_length_next = len_grown;
    end
    if (take_digit && !value_saturated) begin
      if (value_accum > limit) begin
        value_accum_next     = VALUE_MAX;
        value_saturated_next = 1'b1;
      end else begin
        value_accum_next = times_ten;
      end
    end
    if (emit) begin
      scan_state_next = ST_SKIP;
    end
  end

  // newline advances the line, saturating
  always_comb begin
    line_count_next = line_count;
    if (!item.end_of_text && item.ch == CH_NL && line_count != '1) begin
      line_count_next = line_count + 1'b1;
    end
  end

  // result fields, line taken before any newline advance
  always_comb begin
    res.kind      = emit_kind;
    res.line      = line_count;
    res.int_value = (emit_kind == K_INT) ? value_accum : '0;
    res.overflow  = (emit_kind == K_INT) && value_saturated;
    res.length    = literal_length_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state      <= ST_SKIP;
      line_count      <= {{(LINE_BITS-1){1'b0}}, 1'b1};
      value_accum     <= '0;
      value_saturated <= 1'b0;
      literal_length  <= '0;
    end else if (fire) begin
      scan_state      <= scan_state_next;
      line_count      <= line_count_next;
      value_accum     <= value_accum_next;
      value_saturated <= value_saturated_next;
      literal_length  <= literal_length_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/nlscan_out_reg.sv
// nlscan_out_reg: result register between the scanner and the receiver
// depends on nlscan_pkg
`timescale 1ns / 1ps
`default_nettype none

module nlscan_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire nlscan_pkg::res_t res_in,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output nlscan_pkg::res_t      res_q
);
  import nlscan_pkg::*;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res_in;
    end
  end

endmodule

`default_nettype wire

>>> rtl/nlscan_checker.sv
// nlscan_checker: port-level checks on the scanner's results, bound to the
// top level; depends on nlscan_pkg
`timescale 1ns / 1ps
`default_nettype none

module nlscan_checker (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  input  wire logic                               in_ready,
  input  wire logic [7:0]                         ch,
  input  wire logic                               end_of_text,
  input  wire logic                               out_valid,
  input  wire logic                               out_ready,
  input  wire logic [1:0]                         kind,
  input  wire logic [nlscan_pkg::LINE_BITS-1:0]   line,
  input  wire logic [nlscan_pkg::VALUE_BITS-1:0]  int_value,
  input  wire logic                               overflow,
  input  wire logic [nlscan_pkg::LENGTH_BITS-1:0] length
);
  import nlscan_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(line)
      && $stable(int_value) && $stable(overflow) && $stable(length))
    else $error("result changed while stalled");

  // only integers carry a value or overflow
  a_nonint: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != K_INT |-> int_value == '0 && !overflow)
    else $error("non-integer result with value");

  // every literal has at least one character and a line from one
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> length != '0 && line != '0)
    else $error("zero length or line");

  // overflow means a saturated value
  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> int_value == '1)
    else $error("overflow without saturated value");

  // the result register is empty once reset has been applied
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind numeric_literal_scanner nlscan_checker u_nlscan_checker (.*);

`default_nettype wire

>>> verif/nlscan_literal_checker.sv
// nlscan_literal_checker: watches both channels of the numeric literal scanner,
// predicts each literal report from the accepted characters and compares them
// depends on nlscan_pkg for widths, kind codes and the result record
`timescale 1ns / 1ps

module nlscan_literal_checker
  import nlscan_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [7:0]             ch,
  input  logic                   end_of_text,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [1:0]             kind,
  input  logic [LINE_BITS-1:0]   line,
  input  logic [VALUE_BITS-1:0]  int_value,
  input  logic                   overflow,
  input  logic [LENGTH_BITS-1:0] length,
  output int                     fail_count,
  output int                     pending,
  output int                     reports_seen,
  output int                     top_line
);

  typedef enum logic [2:0] {
    S_SKIP, S_INT, S_DOT_PENDING, S_FRAC, S_EXP_START, S_EXP_SIGN, S_EXP_DIGITS
  } scan_state_e;

  localparam logic [7:0] C_ZERO  = "0";
  localparam logic [7:0] C_NINE  = "9";
  localparam logic [7:0] C_DOT   = ".";
  localparam logic [7:0] C_LOW_E = "e";
  localparam logic [7:0] C_UP_E  = "E";
  localparam logic [7:0] C_PLUS  = "+";
  localparam logic [7:0] C_MINUS = "-";
  localparam logic [7:0] C_SPACE = " ";
  localparam logic [7:0] C_NL    = 8'h0A;

  localparam longint unsigned VALUE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int LINE_MAX = (1 << LINE_BITS) - 1;
  localparam int LEN_MAX  = (1 << LENGTH_BITS) - 1;

  // scanner model state
  scan_state_e     scan_st;
  int              line_cnt;
  longint unsigned value_acc;
  bit              value_sat;
  int              lit_len;

  res_t expected_literals[$];

  initial begin
    fail_count   = 0;
    pending      = 0;
    reports_seen = 0;
    top_line     = 0;
  end

  // saturating length count
  function automatic void grow_length(input int n);
    lit_len = lit_len + n;
    if (lit_len > LEN_MAX) lit_len = LEN_MAX;
  endfunction

  // times-ten accumulate with saturation
  function automatic void add_digit(input longint unsigned d);
    if (value_sat) return;
    if (value_acc > (VALUE_MAX - d) / 10) begin
      value_acc = VALUE_MAX;
      value_sat = 1'b1;
    end else begin
      value_acc = value_acc * 10 + d;
    end
  endfunction

  // close the current literal with the given kind
  function automatic res_t close_literal(input logic [1:0] k);
    res_t r;
    r.kind      = k;
    r.line      = LINE_BITS'(line_cnt);
    r.int_value = (k == K_INT) ? value_acc[VALUE_BITS-1:0] : '0;
    r.overflow  = (k == K_INT) && value_sat;
    r.length    = LENGTH_BITS'(lit_len);
    scan_st     = S_SKIP;
    return r;
  endfunction

  // one character through the scanner model
  task automatic scan_char(input logic [7:0] c_in, input logic eot,
                           output bit hit, output res_t r);
    logic [7:0] c;
    bit dig, dot, ee, sg;
    c   = eot ? C_SPACE : c_in;
    dig = (c >= C_ZERO) && (c <= C_NINE);
    dot = (c == C_DOT);
    ee  = (c == C_LOW_E) || (c == C_UP_E);
    sg  = (c == C_PLUS) || (c == C_MINUS);
    hit = 1'b0;
    r   = '0;
    case (scan_st)
      S_SKIP: if (dig) begin
        scan_st   = S_INT;
        value_acc = longint'(c - C_ZERO);
        value_sat = 1'b0;
        lit_len   = 1;
      end
      S_INT: begin
        if (dig) begin
          add_digit(longint'(c - C_ZERO));
          grow_length(1);
        end else if (dot) begin
          scan_st = S_DOT_PENDING;
        end else if (ee) begin
          grow_length(1);
          scan_st = S_EXP_START;
        end else begin
          r = close_literal(K_INT); hit = 1'b1;
        end
      end
      S_DOT_PENDING: begin
        if (dig) begin
          grow_length(2);
          scan_st = S_FRAC;
        end else begin
          r = close_literal(K_INT); hit = 1'b1;
        end
      end
      S_FRAC: begin
        if (dig) begin
          grow_length(1);
        end else if (dot) begin
          grow_length(1);
          r = close_literal(K_DOT); hit = 1'b1;
        end else if (ee) begin
          grow_length(1);
          scan_st = S_EXP_START;
        end else begin
          r = close_literal(K_REAL); hit = 1'b1;
        end
      end
      S_EXP_START: begin
        if (ee) begin
          grow_length(1);
          r = close_literal(K_EXP); hit = 1'b1;
        end else if (sg) begin
          grow_length(1);
          scan_st = S_EXP_SIGN;
        end else if (dig) begin
          grow_length(1);
          scan_st = S_EXP_DIGITS;
        end else begin
          r = close_literal(K_EXP); hit = 1'b1;
        end
      end
      S_EXP_SIGN: begin
        if (sg) begin
          grow_length(1);
          r = close_literal(K_EXP); hit = 1'b1;
        end else if (dig) begin
          grow_length(1);
          scan_st = S_EXP_DIGITS;
        end else begin
          r = close_literal(K_EXP); hit = 1'b1;
        end
      end
      S_EXP_DIGITS: begin
        if (dig) begin
          grow_length(1);
        end else if (ee) begin
          grow_length(1);
          r = close_literal(K_EXP); hit = 1'b1;
        end else begin
          r = close_literal(K_REAL); hit = 1'b1;
        end
      end
      default: scan_st = S_SKIP;
    endcase
    // newline moves the line count, end of text does not
    if (!eot && c == C_NL && line_cnt < LINE_MAX) line_cnt++;
  endtask

  // field by field comparison against the oldest prediction
  task automatic check_literal(input res_t want);
    if (kind !== want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, kind);
      fail_count++;
    end
    if (line !== want.line) begin
      $error("line: expected %0d, got %0d", want.line, line);
      fail_count++;
    end
    if (int_value !== want.int_value) begin
      $error("int_value: expected %0d, got %0d", want.int_value, int_value);
      fail_count++;
    end
    if (overflow !== want.overflow) begin
      $error("overflow: expected %0d, got %0d", want.overflow, overflow);
      fail_count++;
    end
    if (length !== want.length) begin
      $error("length: expected %0d, got %0d", want.length, length);
      fail_count++;
    end
  endtask

  // channel monitor
  always @(posedge clk) begin
    bit   hit;
    res_t predicted;
    if (rst) begin
      scan_st   = S_SKIP;
      line_cnt  = 1;
      value_acc = 0;
      value_sat = 1'b0;
      lit_len   = 0;
      expected_literals.delete();
    end else begin
      if (out_valid && out_ready) begin
        reports_seen++;
        if (line > top_line) top_line = line;
        if (expected_literals.size() == 0) begin
          $error("unexpected report: kind %0d line %0d length %0d", kind, line, length);
          fail_count++;
        end else begin
          check_literal(expected_literals.pop_front());
        end
      end
      if (in_valid && in_ready) begin
        scan_char(ch, end_of_text, hit, predicted);
        if (hit) expected_literals = {expected_literals, predicted};
      end
    end
    pending = expected_literals.size();
  end

endmodule

>>> verif/tb_numeric_literal_scanner.sv
// tb_numeric_literal_scanner: drives text into the numeric literal scanner
// under several idling phases and gives the verdict
// depends on nlscan_pkg, numeric_literal_scanner and nlscan_literal_checker
`timescale 1ns / 1ps

module tb_numeric_literal_scanner;
  import nlscan_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_CHARS    = 100;

  localparam logic [7:0] C_ZERO  = "0";
  localparam logic [7:0] C_DOT   = ".";
  localparam logic [7:0] C_LOW_E = "e";
  localparam logic [7:0] C_UP_E  = "E";
  localparam logic [7:0] C_PLUS  = "+";
  localparam logic [7:0] C_MINUS = "-";
  localparam logic [7:0] C_SPACE = " ";
  localparam logic [7:0] C_TAB   = 8'h09;
  localparam logic [7:0] C_NL    = 8'h0A;
  localparam logic [7:0] C_VT    = 8'h0B;
  localparam logic [7:0] C_FF    = 8'h0C;
  localparam logic [7:0] C_CR    = 8'h0D;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   in_valid    = 1'b0;
  logic                   in_ready;
  logic [7:0]             ch          = '0;
  logic                   end_of_text = 1'b0;
  logic                   out_valid;
  logic                   out_ready   = 1'b0;
  logic [1:0]             kind;
  logic [LINE_BITS-1:0]   line;
  logic [VALUE_BITS-1:0]  int_value;
  logic                   overflow;
  logic [LENGTH_BITS-1:0] length;

  int fail_count, pending, reports_seen, top_line;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int chars_sent     = 0;
  int quiet_cycles   = 0;

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  numeric_literal_scanner dut (
    .clk, .rst, .in_valid, .in_ready, .ch, .end_of_text,
    .out_valid, .out_ready, .kind, .line, .int_value, .overflow, .length
  );

  nlscan_literal_checker u_checker (
    .clk, .rst, .in_valid, .in_ready, .ch, .end_of_text,
    .out_valid, .out_ready, .kind, .line, .int_value, .overflow, .length,
    .fail_count, .pending, .reports_seen, .top_line
  );

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles with no request or report moving
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one character request; called and returns at a falling edge
  task automatic send_char(input logic [7:0] c, input logic eot);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    ch          <= c;
    end_of_text <= eot;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_char(s[i], 1'b0);
  endtask

  task automatic send_digits(input int n);
    repeat (n) send_char(8'(C_ZERO + $urandom_range(9)), 1'b0);
  endtask

  function automatic logic [7:0] pick_e();
    return $urandom_range(1) ? C_LOW_E : C_UP_E;
  endfunction

  function automatic logic [7:0] pick_sign();
    return $urandom_range(1) ? C_PLUS : C_MINUS;
  endfunction

  // one random token: mostly well formed literals, some broken, some noise
  task automatic send_random_token();
    int shape, sep;
    shape = $urandom_range(99);
    if (shape < 12) begin
      repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(255)), 1'b0);
    end else begin
      // integer part, now and then long enough to saturate
      send_digits(($urandom_range(19) == 0) ? $urandom_range(18, 22) : $urandom_range(1, 5));
      if ($urandom_range(1)) begin
        send_char(C_DOT, 1'b0);
        if ($urandom_range(9) != 0) begin
          send_digits($urandom_range(1, 3));
          if ($urandom_range(9) == 0) send_char(C_DOT, 1'b0);
        end
      end
      if ($urandom_range(2) == 0) begin
        send_char(pick_e(), 1'b0);
        case ($urandom_range(9))
          0: send_char(pick_e(), 1'b0);
          1: begin
            send_char(pick_sign(), 1'b0);
            send_char(pick_sign(), 1'b0);
          end
          2: ; // exponent left without digits
          default: begin
            if ($urandom_range(1)) send_char(pick_sign(), 1'b0);
            send_digits($urandom_range(1, 3));
            if ($urandom_range(7) == 0) send_char(pick_e(), 1'b0);
          end
        endcase
      end
    end
    // separator, sometimes none so tokens run together
    sep = $urandom_range(11);
    case (sep)
      0, 1, 2: send_char(C_SPACE, 1'b0);
      3:       send_char(C_TAB, 1'b0);
      4, 5:    send_char(C_NL, 1'b0);
      6:       send_char(C_CR, 1'b0);
      7:       send_char(C_VT, 1'b0);
      8:       send_char(C_FF, 1'b0);
      9:       send_char(8'($urandom_range(255)), 1'b1);
      10:      send_char(8'($urandom_range(128, 255)), 1'b0);
      default: ;
    endcase
  endtask

  task automatic run_phase(input int send_pct, input int stall_pct);
    int target;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    target = chars_sent + PHASE_CHARS;
    while (chars_sent < target) send_random_token();
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: each literal form and each error form
    send_text("0 1.5 1.2.3 4e+5 6E-7 8ee 9e++ 2e3e 5e; 3. 7.x");
    send_char(C_NL, 1'b0);
    send_text("12");
    send_char(C_TAB, 1'b0);
    send_text("99.");
    send_char(8'hFF, 1'b1);
    send_text("1e");
    send_char(C_ZERO, 1'b1);
    send_text("5");
    send_char(8'hB5, 1'b0);
    send_text("6.2");
    send_char(C_CR, 1'b0);
    send_text("3e-");
    send_char(C_VT, 1'b0);
    send_text("9223372036854775807 9223372036854775808");
    send_char(C_FF, 1'b0);
    // over-long literal saturates both length and value
    repeat (260) send_char("7", 1'b0);
    send_char(C_SPACE, 1'b0);

    // random text under each idling pattern
    run_phase(0, 0);
    run_phase(62, 0);
    run_phase(0, 62);
    run_phase(35, 35);

    // closing literals at full rate, flushed by end of text
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_text("42 3.25e7");
    send_char(C_SPACE, 1'b1);
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("sent %0d characters across no-idle, sender-idle, receiver-stall and mixed phases",
             chars_sent);
    $display("checked %0d literal reports, highest line reported %0d", reports_seen, top_line);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
